// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the framer modules.
// SCF_ASSERT expects clk and rst_n in the scope of the module that uses it; SCF_ASSERT_ALWAYS expects clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCF_ASSERT(lbl, prop, msg)
`define SCF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/scf_pkg.sv =====
// Types and constants of the servo command framer.
// Used by scf_ctrl, scf_dp and servo_command_framer; depends on nothing.
package scf_pkg;

  localparam int FIN_W = 2;
  localparam int ANG_W = 26;
  localparam int Q_W   = 21;

  typedef struct packed {
    logic [1:0]         mode;
    logic               armed;
    logic               test_valid;
    logic [9:0]         test_function;
    logic signed [15:0] test_value;
    logic signed [15:0] cmd_fin0;
    logic signed [15:0] cmd_fin1;
    logic signed [15:0] cmd_fin2;
    logic signed [15:0] cmd_fin3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } out_item_t;

  localparam logic [1:0] MODE_NORM = 2'd1;
  localparam logic [1:0] MODE_RAD  = 2'd2;

  localparam logic [2:0] STEP_MUL_IN    = 3'd0;
  localparam logic [2:0] STEP_CLAMP     = 3'd1;
  localparam logic [2:0] STEP_MUL_GAIN  = 3'd2;
  localparam logic [2:0] STEP_OFFSET    = 3'd3;
  localparam logic [2:0] STEP_MUL_RECIP = 3'd4;

  localparam logic [2:0] BYTE_SYNC   = 3'd0;
  localparam logic [2:0] BYTE_ID     = 3'd1;
  localparam logic [2:0] BYTE_POS_HI = 3'd2;
  localparam logic [2:0] BYTE_POS_LO = 3'd3;
  localparam logic [2:0] BYTE_CHECK  = 3'd4;

  localparam logic [13:0]             SCALE_RESET = 14'd5120;
  localparam logic signed [ANG_W-1:0] ANG_LIMIT   = 26'sd26214400;
  localparam logic [29:0]             RAD2DEG_Q24 = 30'd961263669;
  localparam logic [15:0]             POS_GAIN    = 16'd32764;
  localparam logic signed [42:0]      POS_OFFSET  = 43'sd858888601600;
  localparam logic [21:0]             RECIP_100   = 22'd2684355;
  localparam logic [13:0]             POS_CENTER  = 14'd8191;
  localparam logic [13:0]             POS_MAX     = 14'd16383;
  localparam logic [10:0]             FIRST_ID    = 11'h601;
  localparam logic [9:0]              FIRST_FUNC  = 10'd201;
  localparam logic [9:0]              LAST_FUNC   = 10'd204;
  localparam logic [7:0]              SYNC_BASE   = 8'h88;

  typedef struct packed {
    logic             capture;
    logic             calc;
    logic [2:0]       step;
    logic [FIN_W-1:0] fin;
    logic [2:0]       byte_sel;
    logic             emit;
    logic             center_frame;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic center;
    logic send_data;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/servo_command_framer.sv =====
// Servo command framer: one input beat per control tick gives up to eight
// 5-byte servo frames; within a frame, one output beat per cycle while out_stall is low.
// After acceptance the start state picks the centering frames, if they lead, or the
// 5 calculation steps of the first data frame; each data frame follows its 5 steps.
// The input stalls until all frames of the tick are out, output stalls included.
// Synchronous active-low reset clears the arm history and sets scale_r to 20 deg.
module servo_command_framer #(
  parameter int FIN_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [13:0]        cfg_data
);

  scf_pkg::dp_cmd_t    cmd;
  scf_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  scf_ctrl #(
    .FIN_COUNT (FIN_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  scf_dp #(
    .FIN_COUNT (FIN_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/scf_dp.sv =====
// Datapath of the servo command framer: item capture, angle arithmetic,
// frame byte assembly and the output register. Depends on scf_pkg.
`include "assert_macros.svh"
module scf_dp #(
  parameter int FIN_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scf_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic [13:0]         cfg_data,
  input  scf_pkg::dp_cmd_t    cmd,
  output scf_pkg::dp_status_t status,
  input  logic                out_stall,
  output logic                out_valid,
  output scf_pkg::out_item_t  out_data
);

  typedef enum logic [1:0] {SRC_NONE, SRC_NORM, SRC_TEST, SRC_RAD} src_t;

  logic [13:0]                     scale_r;
  scf_pkg::in_item_t               item_r;
  logic                            prev_armed_r;
  logic                            center_r;
  logic                            out_valid_r;
  scf_pkg::out_item_t              out_data_r;
  logic signed [46:0]              prod1_r;
  logic signed [scf_pkg::ANG_W-1:0] ang_r;
  logic signed [42:0]              prod2_r;
  logic [scf_pkg::Q_W-1:0]         q_r;
  logic [42:0]                     prod3_r;

  logic [9:0]                      tf_off;
  logic                            test_hit;
  logic [scf_pkg::FIN_W-1:0]       test_fin;
  src_t                            src;
  logic signed [15:0]              fin_cmd;
  logic signed [15:0]              mul_a;
  logic signed [30:0]              mul_b;
  logic signed [47:0]              ang_full;
  logic signed [42:0]              num;
  logic [14:0]                     pos_raw;
  logic [13:0]                     pos_calc;
  logic [13:0]                     pos;
  logic [10:0]                     frame_id;
  logic [7:0]                      b0, b1, b2, b3, byte_val;
  logic                            out_free;

  assign tf_off   = item_r.test_function - scf_pkg::FIRST_FUNC;
  assign test_fin = tf_off[scf_pkg::FIN_W-1:0];
  assign test_hit = item_r.test_valid &&
                    item_r.test_function >= scf_pkg::FIRST_FUNC &&
                    item_r.test_function <= scf_pkg::LAST_FUNC &&
                    ({22'd0, tf_off} < 32'(FIN_COUNT));

  always_comb begin
    if (item_r.armed && item_r.mode == scf_pkg::MODE_NORM) begin
      src = SRC_NORM;
    end else if (test_hit) begin
      src = SRC_TEST;
    end else if (item_r.armed && item_r.mode == scf_pkg::MODE_RAD) begin
      src = SRC_RAD;
    end else begin
      src = SRC_NONE;
    end
  end

  always_comb begin
    case (cmd.fin)
      2'd0:    fin_cmd = item_r.cmd_fin0;
      2'd1:    fin_cmd = item_r.cmd_fin1;
      2'd2:    fin_cmd = item_r.cmd_fin2;
      2'd3:    fin_cmd = item_r.cmd_fin3;
      default: fin_cmd = '0;
    endcase
  end

  always_comb begin
    case (src)
      SRC_NORM, SRC_RAD: mul_a = fin_cmd;
      SRC_TEST:          mul_a = (cmd.fin == test_fin) ? item_r.test_value : 16'sd0;
      default:           mul_a = 16'sd0;
    endcase
    if (src == SRC_RAD) begin
      mul_b = $signed({1'b0, scf_pkg::RAD2DEG_Q24});
    end else begin
      mul_b = $signed({17'd0, scale_r});
    end
  end

  // Radian products carry 36 fraction bits and are rounded half up to 20.
  always_comb begin
    if (src == SRC_RAD) begin
      ang_full = (48'(prod1_r) + 48'sd32768) >>> 16;
    end else begin
      ang_full = 48'(prod1_r);
    end
  end

  assign num      = prod2_r + scf_pkg::POS_OFFSET;
  assign pos_raw  = prod3_r[42:28];
  assign pos_calc = (pos_raw > 15'(scf_pkg::POS_MAX)) ? scf_pkg::POS_MAX : pos_raw[13:0];
  assign pos      = cmd.center_frame ? scf_pkg::POS_CENTER : pos_calc;
  assign frame_id = scf_pkg::FIRST_ID + 11'(cmd.fin);
  assign b0       = scf_pkg::SYNC_BASE | {6'd0, frame_id[8:7]};
  assign b1       = {1'b0, frame_id[6:0]};
  assign b2       = {1'b0, pos[13:7]};
  assign b3       = {1'b0, pos[6:0]};

  always_comb begin
    case (cmd.byte_sel)
      scf_pkg::BYTE_SYNC:   byte_val = b0;
      scf_pkg::BYTE_ID:     byte_val = b1;
      scf_pkg::BYTE_POS_HI: byte_val = b2;
      scf_pkg::BYTE_POS_LO: byte_val = b3;
      scf_pkg::BYTE_CHECK:  byte_val = b0 ^ b1 ^ b2 ^ b3;
      default:              byte_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= scf_pkg::SCALE_RESET;
      prev_armed_r <= 1'b0;
      center_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_data;
      end
      if (cmd.capture) begin
        prev_armed_r <= in_data.armed;
        center_r     <= prev_armed_r && !in_data.armed;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.emit) begin
      out_data_r.frame_byte <= byte_val;
      out_data_r.last       <= cmd.last;
    end
    if (cmd.calc) begin
      case (cmd.step)
        scf_pkg::STEP_MUL_IN: begin
          prod1_r <= 47'(mul_a) * 47'(mul_b);
        end
        scf_pkg::STEP_CLAMP: begin
          if (ang_full > 48'(scf_pkg::ANG_LIMIT)) begin
            ang_r <= scf_pkg::ANG_LIMIT;
          end else if (ang_full < -48'(scf_pkg::ANG_LIMIT)) begin
            ang_r <= -scf_pkg::ANG_LIMIT;
          end else begin
            ang_r <= ang_full[scf_pkg::ANG_W-1:0];
          end
        end
        scf_pkg::STEP_MUL_GAIN: begin
          prod2_r <= 43'(ang_r) * 43'($signed({1'b0, scf_pkg::POS_GAIN}));
        end
        scf_pkg::STEP_OFFSET: begin
          q_r <= num[42] ? '0 : num[40:20];
        end
        scf_pkg::STEP_MUL_RECIP: begin
          prod3_r <= 43'(q_r) * 43'(scf_pkg::RECIP_100);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free         = !out_valid_r || !out_stall;
  assign status.center    = center_r;
  assign status.send_data = (src != SRC_NONE);
  assign status.out_free  = out_free;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

  `SCF_ASSERT(a_valid_from_emit, $rose(out_valid_r) |-> $past(cmd.emit), "beat without emit")
  `SCF_ASSERT(a_hold_stalled, out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r), "stalled beat changed")
  `SCF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// ===== hdl/scf_ctrl.sv =====
// Controller of the servo command framer: sequences centering frames, the
// angle calculation steps and the data frames. Depends on scf_pkg.
`include "assert_macros.svh"
module scf_ctrl #(
  parameter int FIN_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scf_pkg::dp_status_t status,
  output scf_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_CALC, S_EMIT} state_t;

  localparam logic [scf_pkg::FIN_W-1:0] LAST_FIN = scf_pkg::FIN_W'(FIN_COUNT - 1);
  localparam logic [scf_pkg::FIN_W-1:0] FIN_STEP = scf_pkg::FIN_W'(1);

  state_t                    state_r;
  logic [scf_pkg::FIN_W-1:0] fin_r;
  logic [2:0]                byte_r;
  logic [2:0]                step_r;
  logic                      phase_r;

  assign in_stall         = (state_r != S_IDLE);
  assign cmd.capture      = in_valid && (state_r == S_IDLE);
  assign cmd.calc         = (state_r == S_CALC);
  assign cmd.step         = step_r;
  assign cmd.fin          = fin_r;
  assign cmd.byte_sel     = byte_r;
  assign cmd.emit         = (state_r == S_EMIT) && status.out_free;
  assign cmd.center_frame = phase_r;
  assign cmd.last         = (byte_r == scf_pkg::BYTE_CHECK) && (fin_r == LAST_FIN) &&
                            (!phase_r || !status.send_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= '0;
      byte_r  <= scf_pkg::BYTE_SYNC;
      step_r  <= scf_pkg::STEP_MUL_IN;
      phase_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.capture) begin
            state_r <= S_START;
          end
        end
        S_START: begin
          fin_r  <= '0;
          byte_r <= scf_pkg::BYTE_SYNC;
          step_r <= scf_pkg::STEP_MUL_IN;
          if (status.center) begin
            phase_r <= 1'b1;
            state_r <= S_EMIT;
          end else if (status.send_data) begin
            phase_r <= 1'b0;
            state_r <= S_CALC;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CALC: begin
          if (step_r == scf_pkg::STEP_MUL_RECIP) begin
            step_r  <= scf_pkg::STEP_MUL_IN;
            state_r <= S_EMIT;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_EMIT: begin
          if (cmd.emit) begin
            if (byte_r == scf_pkg::BYTE_CHECK) begin
              byte_r <= scf_pkg::BYTE_SYNC;
              if (fin_r == LAST_FIN) begin
                fin_r <= '0;
                if (phase_r && status.send_data) begin
                  phase_r <= 1'b0;
                  state_r <= S_CALC;
                end else begin
                  state_r <= S_IDLE;
                end
              end else begin
                fin_r   <= fin_r + FIN_STEP;
                state_r <= phase_r ? S_EMIT : S_CALC;
              end
            end else begin
              byte_r <= byte_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `SCF_ASSERT(a_byte_range, byte_r <= scf_pkg::BYTE_CHECK, "byte index out of frame")
  `SCF_ASSERT(a_last_idle, cmd.emit && cmd.last |=> state_r == S_IDLE, "work after last beat")
  `SCF_ASSERT(a_calc_data, state_r == S_CALC |-> status.send_data && !phase_r, "calc without data")

endmodule
